FILE: rtl/aimp_pkg.sv
// Shared types and method codes for the immediate materialization planner.
`timescale 1ns / 1ps

package aimp_pkg;

  // Load method codes carried in the result
  typedef enum logic [2:0] {
    METHOD_MOV     = 3'd0,
    METHOD_MVN     = 3'd1,
    METHOD_MOV_ORR = 3'd2,
    METHOD_MVN_BIC = 3'd3,
    METHOD_LITPOOL = 3'd4
  } method_e;

  // Zero byte window found by the split search, rotated to the bottom
  typedef struct packed {
    logic        found;
    logic [31:0] val;
    logic [4:0]  rot;
  } win_t;

  // Two-immediate split outcome
  typedef struct packed {
    logic        ok;
    logic [11:0] first;
    logic [11:0] second;
  } pair_t;

  // Single rotated immediate outcome
  typedef struct packed {
    logic        ok;
    logic [11:0] op;
  } sgl_t;

endpackage

FILE: rtl/aimp_window.sv
// Zero byte window search that starts the two-immediate split.
`timescale 1ns / 1ps

module aimp_window import aimp_pkg::*; (
  input  logic [31:0] value_i,
  output win_t        win_o
);

  logic [63:0] dbl;
  logic [31:0] vp;
  win_t        hi_win;
  win_t        lo_win;

  assign dbl = {value_i, value_i};
  assign vp  = dbl[55:24];

  // Scan windows from the low end up; the highest clear window wins
  always_comb begin
    hi_win = '0;
    for (int i = 11; i >= 0; i--) begin
      if (value_i[(31 - 2 * i) -: 8] == 8'h00) begin
        hi_win.found = 1'b1;
        hi_win.val   = dbl[(55 - 2 * i) -: 32];
        hi_win.rot   = 5'(8 + i);
      end
    end
  end

  // Fall back to windows that wrap across the low end of the word
  always_comb begin
    lo_win = '0;
    for (int i = 3; i >= 0; i--) begin
      if (vp[(15 - 2 * i) -: 8] == 8'h00) begin
        lo_win.found = 1'b1;
        lo_win.val   = dbl[(63 - 2 * i) -: 32];
        lo_win.rot   = 5'(4 + i);
      end
    end
  end

  assign win_o = hi_win.found ? hi_win : lo_win;

endmodule

FILE: rtl/aimp_split.sv
// Normalize and peel two rotated immediates off a window-aligned value.
`timescale 1ns / 1ps

module aimp_split import aimp_pkg::*; (
  input  win_t  win_i,
  output pair_t pair_o
);

  logic [31:0] v;
  logic [5:0]  r;
  logic [5:0]  r_a4;
  logic [5:0]  r_a8;

  assign r_a4 = 6'({1'b0, win_i.rot} + 6'd4);
  assign r_a8 = 6'({1'b0, win_i.rot} + 6'd8);

  always_comb begin
    pair_o = '0;
    v      = win_i.val;
    r      = {1'b0, win_i.rot};
    if (win_i.val[31:24] == 8'h00) begin
      // Both bytes already sit below the top byte
      pair_o.ok     = win_i.found;
      pair_o.first  = {r_a4[3:0], win_i.val[23:16]};
      pair_o.second = {r_a8[3:0], win_i.val[15:8]};
    end else begin
      if (win_i.val[31:30] != 2'b00) begin
        // Take the top byte as is, then skip a clear byte
        pair_o.first = {r[3:0], v[31:24]};
        v = v << 8;
        r = r + 6'd4;
        if (v[31:24] == 8'h00) begin
          v = v << 8;
          r = r + 6'd4;
        end
      end else begin
        // Align the leading bits to an even position, then take the byte
        if (v[31:28] == 4'h0) begin
          v = v << 4;
          r = r + 6'd2;
        end
        if (v[31:30] == 2'b00) begin
          v = v << 2;
          r = r + 6'd1;
        end
        pair_o.first = {r[3:0], v[31:24]};
        v = v << 8;
        r = r + 6'd4;
      end
      // Align the remainder and require it to fit one byte
      if (v[31:28] == 4'h0) begin
        v = v << 4;
        r = r + 6'd2;
      end
      if (v[31:30] == 2'b00) begin
        v = v << 2;
        r = r + 6'd1;
      end
      pair_o.ok     = win_i.found && (v[23:0] == 24'h0);
      pair_o.second = {r[3:0], v[31:24]};
    end
  end

endmodule

FILE: rtl/arm_immediate_materialize_planner.sv
// Top level: four-stage pipeline that plans how a 32-bit constant is loaded.
//
//  channel  dir  tdata bits (low to high)                          handshake
//  s_axis   in   value[31:0]                                       tvalid/tready
//  m_axis   out  method[2:0] first_operand[14:3] second_operand[26:15], zero pad
//
// One constant enters per cycle while m_axis accepts, and its plan passes the
// input register, single-immediate and window search, split normalization and
// method select into the output register. Throughput is one item per cycle unless m_axis stalls.
// rst_ni clears only the stage valid bits; the datapath registers have no reset.
// A stage loads when it is empty or the stage after it moves, so a stalled
// m_axis holds every transfer in place and bubbles still close up.
`timescale 1ns / 1ps

module arm_immediate_materialize_planner import aimp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // value[31:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // method, first_operand, second_operand, zeros
);

  // Encode a value as one rotated immediate
  function automatic sgl_t enc_single(input logic [31:0] val);
    sgl_t        res;
    logic [31:0] w;
    logic [3:0]  r;
    res = '0;
    if (val[31:8] == 24'h0) begin
      res.ok = 1'b1;
      res.op = {4'h0, val[7:0]};
    end else begin
      if (val[31:24] == 8'h00) begin
        w = val << 8;
        r = 4'd8;
      end else begin
        w = {val[7:0], val[31:8]};
        r = 4'd0;
      end
      if (w[31:24] == 8'h00) begin
        w = w << 8;
        r = r + 4'd4;
      end
      if (w[31:28] == 4'h0) begin
        w = w << 4;
        r = r + 4'd2;
      end
      if (w[31:30] == 2'b00) begin
        w = w << 2;
        r = r + 4'd1;
      end
      res.ok = (w[23:0] == 24'h0);
      res.op = {r, w[31:24]};
    end
    return res;
  endfunction

  // Stage valid bits and handshake enables
  logic v1_q, v1_d, v2_q, v2_d, v3_q, v3_d, v4_q, v4_d;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || m_axis_tready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign v1_d = en1 ? s_axis_tvalid_i : v1_q;
  assign v2_d = en2 ? v1_q : v2_q;
  assign v3_d = en3 ? v2_q : v3_q;
  assign v4_d = en4 ? v3_q : v4_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  // Stage 1: capture the constant
  logic [31:0] val_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      val_q <= s_axis_tdata_i;
    end
  end

  // Stage 2: single encodings and window search for value and inverse
  logic [31:0] inv;
  win_t        win_pos, win_neg;
  sgl_t        sgl_pos_q, sgl_neg_q, sgl_pos2_q, sgl_neg2_q;
  win_t        win_pos_q, win_neg_q;

  assign inv = ~val_q;

  aimp_window u_win_pos (
    .value_i(val_q),
    .win_o  (win_pos)
  );

  aimp_window u_win_neg (
    .value_i(inv),
    .win_o  (win_neg)
  );

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sgl_pos_q <= enc_single(val_q);
      sgl_neg_q <= enc_single(inv);
      win_pos_q <= win_pos;
      win_neg_q <= win_neg;
    end
  end

  // Stage 3: split normalization for value and inverse
  pair_t pair_pos, pair_neg;
  pair_t pair_pos_q, pair_neg_q;

  aimp_split u_split_pos (
    .win_i (win_pos_q),
    .pair_o(pair_pos)
  );

  aimp_split u_split_neg (
    .win_i (win_neg_q),
    .pair_o(pair_neg)
  );

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sgl_pos2_q <= sgl_pos_q;
      sgl_neg2_q <= sgl_neg_q;
      pair_pos_q <= pair_pos;
      pair_neg_q <= pair_neg;
    end
  end

  // Stage 4: pick the first method that fits
  method_e     method_d;
  logic [11:0] first_d, second_d;
  method_e     method_q;
  logic [11:0] first_q, second_q;

  always_comb begin
    method_d = METHOD_LITPOOL;
    first_d  = 12'h0;
    second_d = 12'h0;
    if (sgl_pos2_q.ok) begin
      method_d = METHOD_MOV;
      first_d  = sgl_pos2_q.op;
    end else if (sgl_neg2_q.ok) begin
      method_d = METHOD_MVN;
      first_d  = sgl_neg2_q.op;
    end else if (pair_pos_q.ok) begin
      method_d = METHOD_MOV_ORR;
      first_d  = pair_pos_q.first;
      second_d = pair_pos_q.second;
    end else if (pair_neg_q.ok) begin
      method_d = METHOD_MVN_BIC;
      first_d  = pair_neg_q.first;
      second_d = pair_neg_q.second;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      method_q <= method_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  // Drive the ports
  assign s_axis_tready_o = en1;
  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = {5'b0, second_q, first_q, method_q};

endmodule
